// ===== sv/itoa_pkg.sv =====
`default_nettype none
package itoa_pkg;

   // Width of the integer that is formatted; the input port always carries 32 bits.
   localparam int VALUE_BITS = 32;
   // Largest minimum field width that is honored.
   localparam int WIDTH_MAX = 63;
   // Fixed width of the field_width input.
   localparam int FW_BITS = 6;

   // Most digits a magnitude can produce in decimal and in hexadecimal.
   localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int DIGIT_MAX = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int DCNT_W = $clog2(DIGIT_MAX + 1);

   // Characters in one field: the width, or the digits plus a minus sign.
   localparam int TOTAL_MAX = (WIDTH_MAX > DIGIT_MAX + 1) ? WIDTH_MAX : DIGIT_MAX + 1;
   localparam int CNT_W = $clog2(TOTAL_MAX + 1);

   // Division by ten as multiplication by a reciprocal; exact for any 32-bit dividend.
   localparam int MUL_BITS = 32;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam logic [MUL_BITS-1:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;
   localparam int EXT_BITS = VALUE_BITS + 4;

   // Queue between digit extraction and character output; depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [3:0] DIGIT_TEN  = 4'd10;

   // One formatted item: digits with the most significant at index 0.
   typedef struct packed {
      logic [DIGIT_MAX-1:0][3:0] digits;
      logic [DCNT_W-1:0]         ndig;
      logic                      neg;
      logic                      upper;
      logic                      zero_fill;
      logic                      fill_right;
      logic [FW_BITS-1:0]        width;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] letter_base;
      letter_base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < DIGIT_TEN) begin
         return CH_ZERO + 8'(d);
      end
      return letter_base + 8'(d - DIGIT_TEN);
   endfunction

endpackage
`default_nettype wire

// ===== sv/itoa_if.sv =====
`default_nettype none
interface itoa_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        signed_mode;
   logic        base_hex;
   logic        upper_case;
   logic [5:0]  field_width;
   logic [1:0]  pad_flags;

   modport source (output valid, value, signed_mode, base_hex, upper_case, field_width,
                   pad_flags, input ready);
   modport sink (input valid, value, signed_mode, base_hex, upper_case, field_width,
                 pad_flags, output ready);
endinterface

interface itoa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, out_char, last, input ready);
   modport sink (input valid, out_char, last, output ready);
endinterface
`default_nettype wire

// ===== sv/itoa_front.sv =====
`default_nettype none
module itoa_front import itoa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   itoa_req_if.sink  req_if,
   output push_type  push,
   input  logic      full
);

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_DIV,
      F_HEX,
      F_PUSH
   } fstate_type;

   fstate_type             state_ff, state_in;
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   entry_type              entry_ff, entry_in;

   logic [VALUE_BITS-1:0]  v;
   logic                   neg;
   logic [FW_BITS-1:0]     width_sat;
   logic [MUL_BITS-1:0]    mul_a;
   logic [VALUE_BITS-1:0]  q_dec;
   logic [EXT_BITS-1:0]    q_ext;
   logic [EXT_BITS-1:0]    ten_q;
   logic [3:0]             r_dec;
   logic [VALUE_BITS-1:0]  q_hex;

   always_comb begin
      v         = req_if.value[VALUE_BITS-1:0];
      neg       = req_if.signed_mode && !req_if.base_hex && v[VALUE_BITS-1];
      width_sat = (req_if.field_width > FW_BITS'(WIDTH_MAX)) ? FW_BITS'(WIDTH_MAX)
                                                             : req_if.field_width;
      mul_a     = MUL_BITS'(mag_ff);
      q_dec     = VALUE_BITS'(prod_ff >> RECIP_SHIFT);
      q_ext     = EXT_BITS'(q_dec);
      ten_q     = (q_ext << 3) + (q_ext << 1);
      r_dec     = 4'(EXT_BITS'(mag_ff) - ten_q);
      q_hex     = mag_ff >> 4;

      state_in = state_ff;
      mag_in   = mag_ff;
      prod_in  = prod_ff;
      entry_in = entry_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (req_if.valid) begin
               mag_in              = neg ? VALUE_BITS'(~v + 1'b1) : v;
               entry_in.digits     = '0;
               entry_in.ndig       = '0;
               entry_in.neg        = neg;
               entry_in.upper      = req_if.upper_case;
               entry_in.fill_right = req_if.pad_flags[0];
               entry_in.zero_fill  = req_if.pad_flags[1];
               entry_in.width      = width_sat;
               state_in            = req_if.base_hex ? F_HEX : F_MUL;
            end
         end
         F_MUL: begin
            prod_in  = mul_a * RECIP_TEN;
            state_in = F_DIV;
         end
         F_DIV: begin
            entry_in.digits = {entry_ff.digits[DIGIT_MAX-2:0], r_dec};
            entry_in.ndig   = entry_ff.ndig + 1'b1;
            mag_in          = q_dec;
            state_in        = (q_dec == '0) ? F_PUSH : F_MUL;
         end
         F_HEX: begin
            entry_in.digits = {entry_ff.digits[DIGIT_MAX-2:0], mag_ff[3:0]};
            entry_in.ndig   = entry_ff.ndig + 1'b1;
            mag_in          = q_hex;
            state_in        = (q_hex == '0) ? F_PUSH : F_HEX;
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      entry_ff <= entry_in;
   end

   // No request is taken while reset is held.
   assign req_if.ready = (state_ff == F_IDLE) && !reset;
   assign push.push    = (state_ff == F_PUSH);
   assign push.entry   = entry_ff;

endmodule
`default_nettype wire

// ===== sv/itoa_queue.sv =====
`default_nettype none
module itoa_queue import itoa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      avail
);

   entry_type           entries_ff [QUEUE_DEPTH];
   entry_type           entries_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign avail = (count_ff != '0);
   assign head  = entries_ff[rd_ff];

   always_comb begin
      do_push    = push.push && !full;
      do_pop     = pop && avail;
      entries_in = entries_ff;
      wr_in      = wr_ff;
      rd_in      = rd_ff;
      count_in   = count_ff;
      if (do_push) begin
         entries_in[wr_ff] = push.entry;
         wr_in             = wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      entries_ff <= entries_in;
   end

endmodule
`default_nettype wire

// ===== sv/itoa_emit.sv =====
`default_nettype none
module itoa_emit import itoa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       avail,
   output logic       pop,
   itoa_rsp_if.source rsp_if
);

   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic                       sign_ff, sign_in;
   logic [CNT_W-1:0]           lpad_ff, lpad_in;
   logic                       minus_ff, minus_in;
   logic [DIGIT_MAX-1:0][3:0]  digs_ff, digs_in;
   logic [DCNT_W-1:0]          dcnt_ff, dcnt_in;
   logic [CNT_W-1:0]           rpad_ff, rpad_in;
   logic [7:0]                 padch_ff, padch_in;
   logic                       upper_ff, upper_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;

   logic                       take;
   logic                       emit;
   logic                       sign_first;
   logic                       inline_minus;
   logic [FW_BITS-1:0]         w_rest;
   logic [CNT_W-1:0]           w_cnt;
   logic [CNT_W-1:0]           text_len;
   logic [CNT_W-1:0]           pad_n;

   always_comb begin
      take         = !out_valid_ff || rsp_if.ready;
      emit         = (rem_ff != '0) && take;
      pop          = (rem_ff == '0) && avail;

      // A minus sign leads the zeros only when zero padding meets a set width.
      sign_first   = head.neg && (head.width != '0) && head.zero_fill;
      inline_minus = head.neg && !sign_first;
      w_rest       = head.width - FW_BITS'(sign_first);
      w_cnt        = CNT_W'(w_rest);
      text_len     = CNT_W'(head.ndig) + CNT_W'(inline_minus);
      pad_n        = (text_len >= w_cnt) ? '0 : w_cnt - text_len;

      rem_in       = rem_ff;
      sign_in      = sign_ff;
      lpad_in      = lpad_ff;
      minus_in     = minus_ff;
      digs_in      = digs_ff;
      dcnt_in      = dcnt_ff;
      rpad_in      = rpad_ff;
      padch_in     = padch_ff;
      upper_in     = upper_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (pop) begin
         rem_in   = CNT_W'(sign_first) + pad_n + text_len;
         sign_in  = sign_first;
         minus_in = inline_minus;
         lpad_in  = head.fill_right ? '0 : pad_n;
         rpad_in  = head.fill_right ? pad_n : '0;
         digs_in  = head.digits;
         dcnt_in  = head.ndig;
         padch_in = head.zero_fill ? CH_ZERO : CH_SPACE;
         upper_in = head.upper;
      end else if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = (rem_ff == CNT_W'(1));
         rem_in       = rem_ff - 1'b1;
         priority if (sign_ff) begin
            out_char_in = CH_MINUS;
            sign_in     = 1'b0;
         end else if (lpad_ff != '0) begin
            out_char_in = padch_ff;
            lpad_in     = lpad_ff - 1'b1;
         end else if (minus_ff) begin
            out_char_in = CH_MINUS;
            minus_in    = 1'b0;
         end else if (dcnt_ff != '0) begin
            out_char_in = digit_char(digs_ff[0], upper_ff);
            digs_in     = {4'h0, digs_ff[DIGIT_MAX-1:1]};
            dcnt_in     = dcnt_ff - 1'b1;
         end else begin
            out_char_in = padch_ff;
            rpad_in     = rpad_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
      sign_ff     <= sign_in;
      lpad_ff     <= lpad_in;
      minus_ff    <= minus_in;
      digs_ff     <= digs_in;
      dcnt_ff     <= dcnt_in;
      rpad_ff     <= rpad_in;
      padch_ff    <= padch_in;
      upper_ff    <= upper_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_char = out_char_ff;
   assign rsp_if.last     = out_last_ff;

endmodule
`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
`default_nettype none
// Integer field formatter. Each transfer on the request channel carries one integer with its
// format flags, and the block answers with the ASCII text of that integer, one character per
// response transfer, with last set on the final character. Decimal or hexadecimal, lower- or
// upper-case letters; a minus sign appears only for a negative value in signed decimal mode,
// and zero prints as "0". The text is padded to field_width (at most 63) with spaces or zeros,
// on the left or, with pad_flags bit 0, on the right; with zero padding and a nonzero width the
// minus sign precedes the zeros. The front end accepts a request and then extracts the digits:
// each decimal digit takes a multiply state, which registers the product with the reciprocal
// of ten, and a divide state, which forms the quotient and the remainder; each hex digit is
// taken straight from the low nibble. A push state then hands the digits to a two-entry queue.
// The back end loads an entry and then emits its characters one by one, holding while the
// output is stalled; a field has 1 to 63 characters. Because the queue parts the two ends,
// extraction of the next request overlaps the output of the current one; the sustained pace
// is set by the slower end, which is the extraction for unpadded decimal text and the
// character output for wide fields. Output back-pressure stalls the back end first and
// reaches the request channel only once the queue is full.
module integer_to_ascii_formatter import itoa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   itoa_req_if.sink   req_if,
   itoa_rsp_if.source rsp_if
);

   push_type  q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_avail;
   entry_type q_head;

   // Front end: accepts a request, takes the magnitude and extracts its digits.
   itoa_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .push   (q_push),
      .full   (q_full)
   );

   // Short queue of digit sets so that each end can stall on its own.
   itoa_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .pop   (q_pop),
      .head  (q_head),
      .avail (q_avail)
   );

   // Back end: lays out sign, padding and digits and drives the registered output.
   itoa_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .avail  (q_avail),
      .pop    (q_pop),
      .rsp_if (rsp_if)
   );

endmodule
`default_nettype wire

// ===== bench/itoa_checker.sv =====
`timescale 1ns / 1ps
module itoa_checker import itoa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_value,
   input  logic        req_signed_mode,
   input  logic        req_base_hex,
   input  logic        req_upper_case,
   input  logic [5:0]  req_field_width,
   input  logic [1:0]  req_pad_flags,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_char,
   input  logic        rsp_last,
   output int unsigned failures,
   output int unsigned chars_pending,
   output int unsigned items_seen,
   output int unsigned chars_seen
);

   localparam int PAD_RIGHT_BIT = 0;
   localparam int PAD_ZERO_BIT  = 1;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIGIT_SLOTS   = 24;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];

   // Builds the text of one request and appends it to the expected characters.
   function automatic void format_field(input logic [31:0] value, input logic signed_mode,
                                        input logic base_hex, input logic upper_case,
                                        input logic [5:0] field_width,
                                        input logic [1:0] pad_flags);
      logic [VALUE_BITS-1:0] mag;
      logic [7:0]            digs [0:DIGIT_SLOTS-1];
      logic [7:0]            text [$];
      logic [7:0]            letter_a;
      logic [7:0]            pad_ch;
      logic [3:0]            nib;
      logic                  neg;
      logic                  zero_fill;
      logic                  fill_right;
      int                    len;
      int                    width;
      int                    fill;
      text_char_type         tc;

      fill_right = pad_flags[PAD_RIGHT_BIT];
      zero_fill  = pad_flags[PAD_ZERO_BIT];
      letter_a   = upper_case ? CH_UPPER_A : CH_LOWER_A;
      neg        = signed_mode && !base_hex && value[VALUE_BITS-1];
      mag        = neg ? -value[VALUE_BITS-1:0] : value[VALUE_BITS-1:0];
      len        = 0;

      // Digits are collected least significant first.
      if (mag == 0) begin
         digs[0] = CH_ZERO;
         len = 1;
      end else begin
         while (mag != 0) begin
            nib = base_hex ? mag[3:0] : 4'(mag % 10);
            digs[len] = (nib < DIGIT_TEN) ? CH_ZERO + 8'(nib) : letter_a + 8'(nib - DIGIT_TEN);
            len++;
            mag = base_hex ? (mag >> 4) : (mag / 10);
         end
      end

      width = int'(field_width);
      if (width > WIDTH_MAX) begin
         width = WIDTH_MAX;
      end

      // With zero fill and a nonzero width the sign leads and takes one column; otherwise it is part of the text.
      if (neg) begin
         if (width != 0 && zero_fill) begin
            text.push_back(CH_MINUS);
            width--;
         end else begin
            digs[len] = CH_MINUS;
            len++;
         end
      end

      pad_ch = (width > 0 && zero_fill) ? CH_ZERO : CH_SPACE;
      fill = (len >= width) ? 0 : width - len;

      if (!fill_right) begin
         repeat (fill) text.push_back(pad_ch);
      end
      for (int k = len - 1; k >= 0; k--) begin
         text.push_back(digs[k]);
      end
      if (fill_right) begin
         repeat (fill) text.push_back(pad_ch);
      end

      foreach (text[i]) begin
         tc.ch = text[i];
         tc.last = (i == text.size() - 1);
         expected_text.push_back(tc);
      end
   endfunction

   task automatic flag_mismatch(input string what);
      if (failures < REPORT_LIMIT) begin
         $display("[%0t] mismatch on character %0d: %s", $realtime, chars_seen, what);
      end
      failures++;
   endtask

   initial begin
      failures = 0;
      chars_pending = 0;
      items_seen = 0;
      chars_seen = 0;
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            format_field(req_value, req_signed_mode, req_base_hex, req_upper_case,
                         req_field_width, req_pad_flags);
            items_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               flag_mismatch($sformatf("unexpected char 8'h%02h last %0b",
                                       rsp_out_char, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (want.ch !== rsp_out_char || want.last !== rsp_last) begin
                  flag_mismatch($sformatf("expected char 8'h%02h last %0b, got 8'h%02h last %0b",
                                          want.ch, want.last, rsp_out_char, rsp_last));
               end
            end
            chars_seen++;
         end
         chars_pending = expected_text.size();
      end
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   // Pad flag encodings: bit 0 justifies left (fill on the right), bit 1 fills with zeros.
   localparam logic [1:0] PAD_SPACE_LEFT  = 2'b00;
   localparam logic [1:0] PAD_SPACE_RIGHT = 2'b01;
   localparam logic [1:0] PAD_ZERO_LEFT   = 2'b10;
   localparam logic [1:0] PAD_ZERO_RIGHT  = 2'b11;

   // Items per random phase; five phases give roughly 260 random items.
   localparam int PHASE_ITEMS  = 52;
   // Long receiver hold-off used to back the block up into its input.
   localparam int HOLD_CYCLES  = 400;
   // Cycles with no transfer on either channel before the run is declared hung. The longest
   // legitimate quiet stretch is the hold-off above plus one item's worth of output.
   localparam int QUIET_LIMIT  = 4000;
   // Settling time after the last character: longer than one item's full latency.
   localparam int DRAIN_CYCLES = 150;

   typedef enum int {
      PH_DIRECTED,
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE
   } phase_type;

   logic        clock = 1'b0;
   logic        reset;
   phase_type   phase;
   int unsigned failures;
   int unsigned chars_pending;
   int unsigned items_seen;
   int unsigned chars_seen;

   itoa_req_if req_if ();
   itoa_rsp_if rsp_if ();

   integer_to_ascii_formatter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // The checker sees every transfer on both channels, predicts the text of each request
   // and compares it character by character with what the block produces.
   itoa_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_value       (req_if.value),
      .req_signed_mode (req_if.signed_mode),
      .req_base_hex    (req_if.base_hex),
      .req_upper_case  (req_if.upper_case),
      .req_field_width (req_if.field_width),
      .req_pad_flags   (req_if.pad_flags),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_out_char    (rsp_if.out_char),
      .rsp_last        (rsp_if.last),
      .failures        (failures),
      .chars_pending   (chars_pending),
      .items_seen      (items_seen),
      .chars_seen      (chars_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Percentage of cycles in which the sender holds back, by phase.
   function automatic int send_idle_pct(input phase_type ph);
      case (ph)
         PH_SEND_IDLE: return 64;
         PH_BOTH_IDLE: return 29;
         default:      return 0;
      endcase
   endfunction

   // Percentage of cycles in which the receiver stalls, by phase.
   function automatic int recv_stall_pct(input phase_type ph);
      case (ph)
         PH_RECV_STALL: return 64;
         PH_BOTH_IDLE:  return 29;
         default:       return 0;
      endcase
   endfunction

   // Receiver. Ready is redrawn every cycle from the stall rate of the current phase. In the
   // backpressure phase it is held low once for a long stretch, counted here, while the
   // sender keeps offering requests so that the queue inside the block fills and the block
   // stops taking new ones.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_BACKPRESSURE && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct(phase));
         end
      end
   end

   // Watchdog. Any transfer on either channel restarts the count, so a slow but live block
   // never trips it; a hung one does.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[%0t] no transfer for %0d cycles", $realtime, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Offers one request and returns once it has been transferred. Any idle cycles come first,
   // so valid is never dropped and raised in the same step between back-to-back requests.
   task automatic send_item(input logic [31:0] value, input logic signed_mode,
                            input logic base_hex, input logic upper_case,
                            input logic [5:0] field_width, input logic [1:0] pad_flags);
      while ($urandom_range(99) < send_idle_pct(phase)) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.value       <= value;
      req_if.signed_mode <= signed_mode;
      req_if.base_hex    <= base_hex;
      req_if.upper_case  <= upper_case;
      req_if.field_width <= field_width;
      req_if.pad_flags   <= pad_flags;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // One random request. Values lean toward the interesting corners: full random patterns
   // for bit coverage, small numbers, the signed extremes, small negatives, powers of two and
   // shifted random patterns. Widths are mostly small with an occasional wide field.
   task automatic send_random_item();
      logic [31:0] value;
      logic [5:0]  width;
      case ($urandom_range(9))
         0, 1, 2, 3: value = $urandom;
         4, 5:       value = $urandom_range(999);
         6: begin
            case ($urandom_range(4))
               0:       value = 32'h0000_0000;
               1:       value = 32'h0000_0001;
               2:       value = 32'h7FFF_FFFF;
               3:       value = 32'h8000_0000;
               default: value = 32'hFFFF_FFFF;
            endcase
         end
         7:       value = -32'($urandom_range(1000, 1));
         8:       value = 32'h1 << $urandom_range(31);
         default: value = $urandom >> $urandom_range(31);
      endcase
      width = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
      send_item(value, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                width, 2'($urandom_range(3)));
   endtask

   initial begin
      phase              <= PH_DIRECTED;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.value       <= '0;
      req_if.signed_mode <= 1'b0;
      req_if.base_hex    <= 1'b0;
      req_if.upper_case  <= 1'b0;
      req_if.field_width <= '0;
      req_if.pad_flags   <= PAD_SPACE_LEFT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: zero, the unsigned and signed extremes, both letter cases, the sign
      // ignored outside signed decimal, the minus sign ahead of zero fill, zero fill on the
      // right, text wider than its field, and the widest field in every pad mode.
      send_item(32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd0,  PAD_SPACE_LEFT);
      send_item(32'h0000_0000, 1'b1, 1'b1, 1'b1, 6'd5,  PAD_ZERO_LEFT);
      send_item(32'h0000_0000, 1'b0, 1'b0, 1'b0, 6'd63, PAD_ZERO_RIGHT);
      send_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0,  PAD_SPACE_LEFT);
      send_item(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0,  PAD_SPACE_LEFT);
      send_item(32'h8000_0000, 1'b1, 1'b0, 1'b0, 6'd0,  PAD_SPACE_LEFT);
      send_item(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd12, PAD_SPACE_LEFT);
      send_item(32'hDEAD_BEEF, 1'b0, 1'b1, 1'b0, 6'd0,  PAD_SPACE_LEFT);
      send_item(32'hDEAD_BEEF, 1'b0, 1'b1, 1'b1, 6'd10, PAD_ZERO_LEFT);
      send_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd0,  PAD_SPACE_LEFT);
      send_item(32'h8000_0000, 1'b1, 1'b1, 1'b0, 6'd9,  PAD_SPACE_RIGHT);
      send_item(32'hFFFF_FF85, 1'b1, 1'b0, 1'b0, 6'd12, PAD_SPACE_LEFT);
      send_item(32'hFFFF_FF85, 1'b1, 1'b0, 1'b0, 6'd12, PAD_ZERO_LEFT);
      send_item(32'hFFFF_FF85, 1'b1, 1'b0, 1'b0, 6'd12, PAD_SPACE_RIGHT);
      send_item(32'hFFFF_FF85, 1'b1, 1'b0, 1'b0, 6'd12, PAD_ZERO_RIGHT);
      send_item(32'hFFFF_FF85, 1'b1, 1'b0, 1'b0, 6'd0,  PAD_ZERO_LEFT);
      send_item(32'hFFFF_FF85, 1'b1, 1'b0, 1'b0, 6'd1,  PAD_ZERO_LEFT);
      send_item(32'h0000_3039, 1'b0, 1'b0, 1'b0, 6'd7,  PAD_ZERO_RIGHT);
      send_item(32'd1234567,   1'b1, 1'b0, 1'b0, 6'd3,  PAD_ZERO_LEFT);
      send_item(32'h8000_0000, 1'b1, 1'b0, 1'b0, 6'd63, PAD_ZERO_LEFT);
      send_item(32'h0ABC_DEF0, 1'b0, 1'b1, 1'b1, 6'd63, PAD_SPACE_RIGHT);
      send_item(32'h0000_000A, 1'b0, 1'b1, 1'b0, 6'd63, PAD_SPACE_LEFT);
      send_item(32'd10,        1'b1, 1'b0, 1'b1, 6'd2,  PAD_ZERO_RIGHT);

      // Random phases: free running, sender gaps, receiver stalls, both, and a long receiver
      // hold-off with the sender pushing as hard as it can.
      phase <= PH_FREE;
      repeat (PHASE_ITEMS) send_random_item();
      phase <= PH_SEND_IDLE;
      repeat (PHASE_ITEMS) send_random_item();
      phase <= PH_RECV_STALL;
      repeat (PHASE_ITEMS) send_random_item();
      phase <= PH_BOTH_IDLE;
      repeat (PHASE_ITEMS) send_random_item();
      phase <= PH_BACKPRESSURE;
      repeat (PHASE_ITEMS) send_random_item();
      phase <= PH_FREE;
      req_if.valid <= 1'b0;

      // Let the block finish the text still in flight, then give it time to show any extra
      // characters it should not produce.
      while (chars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d requests into %0d characters across decimal, hex, signed and",
               items_seen, chars_seen);
      $display("every pad mode, under gaps, stalls and a full back-up; %0d still owed.",
               chars_pending);
      if (failures == 0 && chars_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
